// ----- rtl/der_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package der_pkg;

    // One pending request as stored in the table
    typedef struct packed {
        logic [7:0]  requester;
        logic [15:0] cylinder;
        logic [7:0]  track;
        logic [7:0]  record;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    typedef enum logic [1:0] {
        STS_INSERTED   = 2'd0,
        STS_FULL       = 2'd1,
        STS_DISPATCHED = 2'd2,
        STS_EMPTY      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SHIFT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/der_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module der_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/disk_elevator_request_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Elevator (SCAN) disk request scheduler.
// Input channel (in_valid / in_stall): one item is either an insert of a
// request (requester, cylinder, track, record) or a dispatch of the next one.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in input order: status, the granted request, arm direction and the
// number of requests still pending.
// Insert, full-table and empty-table items need no table walk: the result
// sits in the output register in the cycle after acceptance.
// A dispatch walks the request RAM twice through its single read port: a
// scan of all N pending entries to find the best candidate on the head's
// cylinder, above it and below it, then a step to pick one of them, then a
// compaction that moves the younger entries down one slot, and last a step
// that posts the result.
// The next item is taken only when the block is idle and the output register
// is free or being emptied; a stalled receiver holds the result in place and
// backs up the input side through in_stall.
// Reset empties the table (count of zero), points the arm up and parks the
// head at cylinder 0, record 0. The RAM needs no clearing; only entries
// below the count are ever read.
module disk_elevator_request_scheduler
    import der_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  requester,
    input  wire logic [15:0] cylinder,
    input  wire logic [7:0]  track,
    input  wire logic [7:0]  record,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [7:0]       granted_requester,
    output logic [15:0]      granted_cylinder,
    output logic [7:0]       granted_track,
    output logic [7:0]       granted_record,
    output logic             arm_direction,
    output logic [4:0]       pending_count
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Control
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dir_reg, dir_next;
    logic [15:0]        head_cyl_reg, head_cyl_next;
    logic [7:0]         head_rec_reg, head_rec_next;

    // Table walk pointer and read pipeline
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;

    // Best candidates found during the scan
    logic               same_found_reg, same_found_next;
    logic [7:0]         same_dist_reg, same_dist_next;
    logic [AW-1:0]      same_idx_reg, same_idx_next;
    entry_t             same_ent_reg, same_ent_next;
    logic               above_found_reg, above_found_next;
    logic [AW-1:0]      above_idx_reg, above_idx_next;
    entry_t             above_ent_reg, above_ent_next;
    logic               below_found_reg, below_found_next;
    logic [AW-1:0]      below_idx_reg, below_idx_next;
    entry_t             below_ent_reg, below_ent_next;
    entry_t             chosen_reg, chosen_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    entry_t             out_ent_reg, out_ent_next;
    logic               out_dir_reg, out_dir_next;
    logic [4:0]         out_cnt_reg, out_cnt_next;

    // RAM ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_ent;

    logic               accept;
    logic               out_free;
    logic               table_full;
    logic [7:0]         rec_dist;
    logic [31:0]        cnt_ext;

    der_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_ent     = entry_t'(ram_rdata);
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE) || !out_free;
    assign accept     = in_valid && !in_stall;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign rec_dist   = (rd_ent.record > head_rec_reg) ? (rd_ent.record - head_rec_reg)
                                                       : (head_rec_reg - rd_ent.record);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        dir_next         = dir_reg;
        head_cyl_next    = head_cyl_reg;
        head_rec_next    = head_rec_reg;
        scan_idx_next    = scan_idx_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        same_found_next  = same_found_reg;
        same_dist_next   = same_dist_reg;
        same_idx_next    = same_idx_reg;
        same_ent_next    = same_ent_reg;
        above_found_next = above_found_reg;
        above_idx_next   = above_idx_reg;
        above_ent_next   = above_ent_reg;
        below_found_next = below_found_reg;
        below_idx_next   = below_idx_reg;
        below_ent_next   = below_ent_reg;
        chosen_next      = chosen_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_status_next  = out_status_reg;
        out_ent_next     = out_ent_reg;
        out_dir_next     = out_dir_reg;
        out_cnt_next     = out_cnt_reg;
        ram_we           = 1'b0;
        ram_waddr        = count_reg[AW-1:0];
        ram_wdata        = '{requester: requester, cylinder: cylinder,
                             track: track, record: record};
        ram_raddr        = scan_idx_reg[AW-1:0];
        cnt_ext          = 32'(count_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        out_ent_next   = '0;
                        out_dir_next   = dir_reg;
                        if (table_full)
                        begin
                            out_status_next = STS_FULL;
                            out_cnt_next    = cnt_ext[4:0];
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            count_next      = count_reg + 1'b1;
                            cnt_ext         = 32'(count_next);
                            out_status_next = STS_INSERTED;
                            out_cnt_next    = cnt_ext[4:0];
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STS_EMPTY;
                        out_ent_next    = '0;
                        out_dir_next    = dir_reg;
                        out_cnt_next    = cnt_ext[4:0];
                    end
                    else
                    begin
                        scan_idx_next    = '0;
                        same_found_next  = 1'b0;
                        above_found_next = 1'b0;
                        below_found_next = 1'b0;
                        state_next       = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Oldest wins ties: only a strictly better entry replaces a candidate
                if (rd_valid_reg)
                begin
                    if (rd_ent.cylinder == head_cyl_reg &&
                        (!same_found_reg || rec_dist < same_dist_reg))
                    begin
                        same_found_next = 1'b1;
                        same_dist_next  = rec_dist;
                        same_idx_next   = rd_idx_reg;
                        same_ent_next   = rd_ent;
                    end
                    if (rd_ent.cylinder > head_cyl_reg &&
                        (!above_found_reg || rd_ent.cylinder < above_ent_reg.cylinder))
                    begin
                        above_found_next = 1'b1;
                        above_idx_next   = rd_idx_reg;
                        above_ent_next   = rd_ent;
                    end
                    if (rd_ent.cylinder < head_cyl_reg &&
                        (!below_found_reg || rd_ent.cylinder > below_ent_reg.cylinder))
                    begin
                        below_found_next = 1'b1;
                        below_idx_next   = rd_idx_reg;
                        below_ent_next   = rd_ent;
                    end
                end
                if (scan_idx_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_PICK;
                end
            end

            ST_PICK:
            begin
                if (same_found_reg)
                begin
                    chosen_next   = same_ent_reg;
                    scan_idx_next = CNT_W'(same_idx_reg) + 1'b1;
                end
                else if ((dir_reg == DIR_UP && above_found_reg) ||
                         (dir_reg == DIR_DOWN && !below_found_reg))
                begin
                    dir_next      = DIR_UP;
                    chosen_next   = above_ent_reg;
                    scan_idx_next = CNT_W'(above_idx_reg) + 1'b1;
                end
                else
                begin
                    dir_next      = DIR_DOWN;
                    chosen_next   = below_ent_reg;
                    scan_idx_next = CNT_W'(below_idx_reg) + 1'b1;
                end
                head_cyl_next = chosen_next.cylinder;
                head_rec_next = chosen_next.record;
                count_next    = count_reg - 1'b1;
                state_next    = ST_SHIFT;
            end

            ST_SHIFT:
            begin
                // Entry i+1 read last cycle lands in slot i
                if (rd_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_reg - 1'b1;
                    ram_wdata = rd_ent;
                end
                if (scan_idx_reg <= count_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STS_DISPATCHED;
                    out_ent_next    = chosen_reg;
                    out_dir_next    = dir_reg;
                    out_cnt_next    = cnt_ext[4:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            dir_reg         <= DIR_UP;
            head_cyl_reg    <= '0;
            head_rec_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            dir_reg         <= dir_next;
            head_cyl_reg    <= head_cyl_next;
            head_rec_reg    <= head_rec_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        rd_idx_reg      <= rd_idx_next;
        same_found_reg  <= same_found_next;
        same_dist_reg   <= same_dist_next;
        same_idx_reg    <= same_idx_next;
        same_ent_reg    <= same_ent_next;
        above_found_reg <= above_found_next;
        above_idx_reg   <= above_idx_next;
        above_ent_reg   <= above_ent_next;
        below_found_reg <= below_found_next;
        below_idx_reg   <= below_idx_next;
        below_ent_reg   <= below_ent_next;
        chosen_reg      <= chosen_next;
        out_status_reg  <= out_status_next;
        out_ent_reg     <= out_ent_next;
        out_dir_reg     <= out_dir_next;
        out_cnt_reg     <= out_cnt_next;
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign granted_requester = out_ent_reg.requester;
    assign granted_cylinder  = out_ent_reg.cylinder;
    assign granted_track     = out_ent_reg.track;
    assign granted_record    = out_ent_reg.record;
    assign arm_direction     = out_dir_reg;
    assign pending_count     = out_cnt_reg;

    // Insert into a full table is dropped and reported in the next cycle
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_INSERT && table_full)
        |=> (out_valid && status == STS_FULL && count_reg == $past(count_reg)))
        else $error("full-table insert not reported or count changed");

    // A pick always removes exactly one entry
    a_pick_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |=> (count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("dispatch did not remove one entry");

    // Dispatch never starts on an empty table
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK) |-> (same_found_reg || above_found_reg || below_found_reg))
        else $error("scan found no candidate");

    // Compaction writes only below the live count
    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && ram_we) |-> (CNT_W'(ram_waddr) < count_reg))
        else $error("compaction write past the table end");

    // A finished dispatch posts its result when the output register frees up
    a_done_post: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free)
        |=> (out_valid && status == STS_DISPATCHED && state_reg == ST_IDLE))
        else $error("dispatch result not posted");

endmodule

`default_nettype wire
